FILE: design/http_request_stream_parser_macros.svh
// Assertion helpers used by the parser RTL.
// Both expect clk and rst_n in the scope where they are used.
`ifndef HTTP_REQUEST_STREAM_PARSER_MACROS_SVH
`define HTTP_REQUEST_STREAM_PARSER_MACROS_SVH

// Same-cycle implication
`define HRSP_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication
`define HRSP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: design/hrsp_pkg.sv
package hrsp_pkg;

  // Limits
  localparam int MAX_HEADERS     = 16;
  localparam int FIELD_CAP       = 256;
  localparam int BODY_MAX        = 1024;
  localparam int SHORT_FIELD_CAP = 16;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 11;
  localparam int HCNT_W     = 5;
  localparam int SLOT_W     = 4;
  localparam int KIND_W     = 2;
  localparam int FID_W      = 3;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Results per item and queue sizing
  localparam int RES_MAX  = 3;
  localparam int RCNT_W   = 2;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = 1;
  localparam int Q_CNT_W  = 2;

  // Characters
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [KIND_W-1:0] {
    KIND_CONTENT,
    KIND_END,
    KIND_STATUS
  } kind_t;

  typedef enum logic [FID_W-1:0] {
    FID_METHOD,
    FID_PATH,
    FID_VERSION,
    FID_HNAME,
    FID_HVALUE,
    FID_BODY
  } fid_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_BAD_LINE,
    ST_NO_COLON,
    ST_TOO_MANY,
    ST_TOO_LONG,
    ST_INCOMPLETE
  } status_t;

  typedef enum logic [3:0] {
    PH_METHOD,
    PH_PATH,
    PH_VERSION,
    PH_LINE,
    PH_HNAME,
    PH_VSKIP,
    PH_VALUE,
    PH_SKIP_NOCOLON,
    PH_SKIP_COLON,
    PH_BODY,
    PH_ERR
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BODY_LIMIT,
    CFG_HEADER_LIMIT
  } cfg_idx_t;

  typedef struct packed {
    phase_t            phase;
    logic              cr_held;
    logic [LEN_W-1:0]  len;
    logic [HCNT_W-1:0] hnum;
    status_t           err;
  } pstate_t;

  typedef struct packed {
    kind_t             kind;
    fid_t              fid;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  flen;
    logic [HCNT_W-1:0] seen;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic [RCNT_W-1:0]       cnt;
    res_t [RES_MAX-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } qpush_t;

  typedef struct packed {
    pstate_t st;
    logic    hit;
    res_t    res;
  } step_t;

  localparam pstate_t PSTATE_RST = '{
    phase:   PH_METHOD,
    cr_held: 1'b0,
    len:     '0,
    hnum:    '0,
    err:     ST_OK
  };

  function automatic res_t mk_res(kind_t k, fid_t f, logic [SLOT_W-1:0] s,
                                  logic [BYTE_W-1:0] d, logic [LEN_W-1:0] l,
                                  logic [HCNT_W-1:0] seen, status_t st);
    res_t r;
    r.kind   = k;
    r.fid    = f;
    r.slot   = s;
    r.data   = d;
    r.flen   = l;
    r.seen   = seen;
    r.status = st;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] to_lower(logic [BYTE_W-1:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(fid_t f, logic [HCNT_W-1:0] hnum);
    return (f == FID_HNAME || f == FID_HVALUE) ? hnum[SLOT_W-1:0] : '0;
  endfunction

  function automatic step_t fail(pstate_t st, status_t code);
    step_t r;
    r.st         = st;
    r.st.err     = code;
    r.st.phase   = PH_ERR;
    r.st.cr_held = 1'b0;
    r.hit        = 1'b0;
    r.res        = '0;
    return r;
  endfunction

  function automatic step_t put_content(pstate_t st, fid_t f, logic [BYTE_W-1:0] c,
                                        logic [LEN_W-1:0] cap);
    step_t r;
    if (st.len >= cap) begin
      r = fail(st, ST_TOO_LONG);
    end else begin
      r.st     = st;
      r.st.len = st.len + 1'b1;
      r.hit    = 1'b1;
      r.res    = mk_res(KIND_CONTENT, f, slot_of(f, st.hnum), c, '0, '0, ST_OK);
    end
    return r;
  endfunction

  function automatic step_t end_field(pstate_t st, fid_t f);
    step_t r;
    r.st     = st;
    r.st.len = '0;
    r.hit    = 1'b1;
    r.res    = mk_res(KIND_END, f, slot_of(f, st.hnum), '0, st.len, '0, ST_OK);
    return r;
  endfunction

  // One byte while inside a header name
  function automatic step_t hname_byte(pstate_t st, logic [BYTE_W-1:0] c);
    step_t r;
    if (c == CH_COLON) begin
      r          = end_field(st, FID_HNAME);
      r.st.phase = PH_VSKIP;
    end else begin
      r = put_content(st, FID_HNAME, to_lower(c), LEN_W'(FIELD_CAP));
    end
    return r;
  endfunction

  // One content byte outside the body
  function automatic step_t on_content(pstate_t st, logic [BYTE_W-1:0] c,
                                       logic [HCNT_W-1:0] hlim);
    step_t   r;
    pstate_t s;
    r.st  = st;
    r.hit = 1'b0;
    r.res = '0;
    s     = st;
    case (st.phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          r          = end_field(st, FID_METHOD);
          r.st.phase = PH_PATH;
        end else begin
          r = put_content(st, FID_METHOD, c, LEN_W'(SHORT_FIELD_CAP));
        end
      end
      PH_PATH: begin
        if (c == CH_SP) begin
          r          = end_field(st, FID_PATH);
          r.st.phase = PH_VERSION;
        end else begin
          r = put_content(st, FID_PATH, c, LEN_W'(FIELD_CAP));
        end
      end
      PH_VERSION: r = put_content(st, FID_VERSION, c, LEN_W'(SHORT_FIELD_CAP));
      PH_LINE: begin
        if (st.hnum >= hlim) begin
          r.st.phase = (c == CH_COLON) ? PH_SKIP_COLON : PH_SKIP_NOCOLON;
        end else begin
          s.phase = PH_HNAME;
          s.len   = '0;
          r       = hname_byte(s, c);
        end
      end
      PH_HNAME: r = hname_byte(st, c);
      PH_VSKIP: begin
        if (c != CH_SP) begin
          s.phase = PH_VALUE;
          r       = put_content(s, FID_HVALUE, c, LEN_W'(FIELD_CAP));
        end
      end
      PH_VALUE: r = put_content(st, FID_HVALUE, c, LEN_W'(FIELD_CAP));
      PH_SKIP_NOCOLON: begin
        if (c == CH_COLON) r.st.phase = PH_SKIP_COLON;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Line end (CR followed by LF)
  function automatic step_t on_crlf(pstate_t st);
    step_t r;
    r.st  = st;
    r.hit = 1'b0;
    r.res = '0;
    case (st.phase)
      PH_METHOD, PH_PATH: r = fail(st, ST_BAD_LINE);
      PH_VERSION: begin
        r          = end_field(st, FID_VERSION);
        r.st.phase = PH_LINE;
      end
      PH_LINE: begin
        r.st.len   = '0;
        r.st.phase = PH_BODY;
      end
      PH_HNAME, PH_SKIP_NOCOLON: r = fail(st, ST_NO_COLON);
      PH_VSKIP, PH_VALUE: begin
        r          = end_field(st, FID_HVALUE);
        r.st.hnum  = st.hnum + 1'b1;
        r.st.phase = PH_LINE;
      end
      PH_SKIP_COLON: r = fail(st, ST_TOO_MANY);
      default: ;
    endcase
    return r;
  endfunction

endpackage

FILE: design/hrsp_in_if.sv
interface hrsp_in_if;
  logic                           valid;
  logic                           ready;
  logic [hrsp_pkg::BYTE_W-1:0]    data_byte;
  logic                           is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

FILE: design/hrsp_out_if.sv
interface hrsp_out_if;
  logic                           valid;
  logic                           ready;
  logic [hrsp_pkg::KIND_W-1:0]    kind;
  logic [hrsp_pkg::FID_W-1:0]     field_id;
  logic [hrsp_pkg::SLOT_W-1:0]    header_slot;
  logic [hrsp_pkg::BYTE_W-1:0]    out_byte;
  logic [hrsp_pkg::LEN_W-1:0]     field_length;
  logic [hrsp_pkg::HCNT_W-1:0]    headers_seen;
  logic [hrsp_pkg::STAT_W-1:0]    status;
  logic                           run_end;

  modport source (output valid, output kind, output field_id, output header_slot,
                  output out_byte, output field_length, output headers_seen,
                  output status, output run_end, input ready);
  modport sink   (input valid, input kind, input field_id, input header_slot,
                  input out_byte, input field_length, input headers_seen,
                  input status, input run_end, output ready);
endinterface

FILE: design/hrsp_queue.sv
module hrsp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  hrsp_pkg::qpush_t  push,
  output logic              full,
  input  logic              pop,
  output hrsp_pkg::bundle_t head,
  output logic              empty
);
  import hrsp_pkg::*;

  bundle_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store bundle
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.bundle;
  end
endmodule

FILE: design/hrsp_front.sv
module hrsp_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hrsp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [hrsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  hrsp_in_if.sink                          in_if,
  output hrsp_pkg::qpush_t                 push,
  input  logic                             q_full
);
  import hrsp_pkg::*;

  pstate_t            st_r, st_nxt;
  logic [LEN_W-1:0]   body_lim_r;
  logic [HCNT_W-1:0]  hdr_lim_r;
  bundle_t            bnd;
  logic               fire;

  assign in_if.ready = !q_full;
  assign fire        = in_if.valid && in_if.ready;
  assign push.valid  = fire && (bnd.cnt != '0);
  assign push.bundle = bnd;

  // Classify one byte and collect its results
  always_comb begin
    pstate_t           s;
    step_t             r;
    logic              done;
    logic [RCNT_W-1:0] n;
    res_t [RES_MAX-1:0] rs;
    logic [BYTE_W-1:0] b;

    s    = st_r;
    r    = '0;
    done = 1'b0;
    n    = '0;
    rs   = '0;
    b    = in_if.data_byte;

    if (s.phase == PH_BODY) begin
      if (s.len < body_lim_r) begin
        rs[n] = mk_res(KIND_CONTENT, FID_BODY, '0, b, '0, '0, ST_OK);
        n     = n + 1'b1;
        s.len = s.len + 1'b1;
      end
    end else if (s.phase != PH_ERR) begin
      // Resolve a held CR
      if (s.cr_held) begin
        s.cr_held = 1'b0;
        if (b == CH_LF) begin
          r    = on_crlf(s);
          done = 1'b1;
        end else begin
          r = on_content(s, CH_CR, hdr_lim_r);
        end
        s = r.st;
        if (r.hit) begin
          rs[n] = r.res;
          n     = n + 1'b1;
        end
      end
      // Handle the byte itself
      if (!done && s.phase != PH_ERR) begin
        if (b == CH_CR) begin
          s.cr_held = 1'b1;
        end else begin
          r = on_content(s, b, hdr_lim_r);
          s = r.st;
          if (r.hit) begin
            rs[n] = r.res;
            n     = n + 1'b1;
          end
        end
      end
    end

    // Close the buffer with a status
    if (in_if.is_final) begin
      if (s.phase == PH_BODY) begin
        rs[n] = mk_res(KIND_STATUS, FID_METHOD, '0, '0, s.len, s.hnum, ST_OK);
      end else if (s.phase == PH_ERR) begin
        rs[n] = mk_res(KIND_STATUS, FID_METHOD, '0, '0, '0, s.hnum, s.err);
      end else begin
        rs[n] = mk_res(KIND_STATUS, FID_METHOD, '0, '0, '0, s.hnum, ST_INCOMPLETE);
      end
      n = n + 1'b1;
      s = PSTATE_RST;
    end

    st_nxt  = s;
    bnd.cnt = n;
    bnd.res = rs;
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PSTATE_RST;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // Hold clamped limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_lim_r <= LEN_W'(BODY_MAX);
      hdr_lim_r  <= HCNT_W'(MAX_HEADERS);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_BODY_LIMIT: begin
          body_lim_r <= (cfg_data[LEN_W-1:0] > LEN_W'(BODY_MAX)) ?
                        LEN_W'(BODY_MAX) : cfg_data[LEN_W-1:0];
        end
        CFG_HEADER_LIMIT: begin
          hdr_lim_r <= (cfg_data[HCNT_W-1:0] > HCNT_W'(MAX_HEADERS)) ?
                       HCNT_W'(MAX_HEADERS) : cfg_data[HCNT_W-1:0];
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: design/hrsp_back.sv
`include "http_request_stream_parser_macros.svh"

module hrsp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hrsp_pkg::bundle_t head,
  input  logic              q_empty,
  output logic              pop,
  hrsp_out_if.source        out_if
);
  import hrsp_pkg::*;

  bundle_t            bundle_r;
  logic [RCNT_W-1:0]  idx_r;
  logic               valid_r;
  logic               last;
  logic               fire;
  res_t               cur;

  assign cur  = bundle_r.res[idx_r];
  assign last = (idx_r == bundle_r.cnt - 1'b1);
  assign fire = out_if.valid && out_if.ready;
  assign pop  = !q_empty && (!valid_r || (fire && last));

  // Drive result fields
  assign out_if.valid        = valid_r;
  assign out_if.kind         = cur.kind;
  assign out_if.field_id     = cur.fid;
  assign out_if.header_slot  = cur.slot;
  assign out_if.out_byte     = cur.data;
  assign out_if.field_length = cur.flen;
  assign out_if.headers_seen = cur.seen;
  assign out_if.status       = cur.status;
  assign out_if.run_end      = last;

  // Load a bundle, step through its results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (pop) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (fire) begin
      if (last) valid_r <= 1'b0;
      else      idx_r   <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) bundle_r <= head;
  end

  `HRSP_ASSERT_IMPLY(a_idx_in_range, valid_r, idx_r < bundle_r.cnt, "result index past bundle")
  `HRSP_ASSERT_IMPLY(a_no_empty_bundle, valid_r, bundle_r.cnt != '0, "empty bundle loaded")
  `HRSP_ASSERT_IMPLY(a_status_last, out_if.valid && out_if.kind == KIND_STATUS, out_if.run_end, "status not last")
  `HRSP_ASSERT_NEXT(a_item_continues, fire && !last, valid_r && idx_r == $past(idx_r) + 1'b1, "item results cut short")
endmodule

FILE: design/http_request_stream_parser.sv
// Results of an item pass through the bundle queue and the output bundle register.
// Throughput: one item per cycle while items give at most one result each and the
// output is ready; an item with several results shows them one at a time, and the
// two-entry bundle queue between parser and output lets input run ahead.
// Reset (synchronous, rst_n low) returns the parser to the method field, empties
// the queue and restores body_limit to 1024 and header_limit to 16.
module http_request_stream_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hrsp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [hrsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  hrsp_in_if.sink                          in_if,
  hrsp_out_if.source                       out_if
);
  import hrsp_pkg::*;

  qpush_t  push;
  bundle_t head;
  logic    q_full;
  logic    q_empty;
  logic    pop;

  hrsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_if    (in_if),
    .push     (push),
    .q_full   (q_full)
  );

  hrsp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head),
    .empty (q_empty)
  );

  hrsp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_if  (out_if)
  );
endmodule

FILE: test/tb.sv
module tb;
  import hrsp_pkg::*;

  localparam int ITEM_GOAL = 470;

  // One result item as seen on the output channel
  typedef struct {
    kind_t             kind;
    fid_t              fid;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  flen;
    logic [HCNT_W-1:0] seen;
    status_t           status;
    logic              last;
  } token_t;

  // Request parser mirror plus the queue of tokens it still owes
  class parse_tracker;
    phase_t            ph;
    logic              held_cr;
    logic [LEN_W-1:0]  len;
    logic [HCNT_W-1:0] hnum;
    status_t           err;
    logic [LEN_W-1:0]  body_lim;
    logic [HCNT_W-1:0] hdr_lim;
    token_t            step_tokens[$];
    token_t            due_tokens[$];
    int                bad_count;

    function void restart();
      ph      = PH_METHOD;
      held_cr = 1'b0;
      len     = '0;
      hnum    = '0;
      err     = ST_OK;
    endfunction

    function void power_on();
      body_lim  = LEN_W'(BODY_MAX);
      hdr_lim   = HCNT_W'(MAX_HEADERS);
      bad_count = 0;
      due_tokens.delete();
      restart();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_BODY_LIMIT:   body_lim = v[LEN_W-1:0];
        CFG_HEADER_LIMIT: hdr_lim  = v[HCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_token(kind_t k, fid_t f, logic [SLOT_W-1:0] s, logic [BYTE_W-1:0] d,
                            logic [LEN_W-1:0] l, logic [HCNT_W-1:0] n, status_t st);
      token_t t;
      if (step_tokens.size() >= RES_MAX) return;
      t.kind   = k;
      t.fid    = f;
      t.slot   = s;
      t.data   = d;
      t.flen   = l;
      t.seen   = n;
      t.status = st;
      t.last   = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function logic [SLOT_W-1:0] slot_for(fid_t f);
      return (f == FID_HNAME || f == FID_HVALUE) ? hnum[SLOT_W-1:0] : '0;
    endfunction

    function void abort(status_t code);
      err     = code;
      ph      = PH_ERR;
      held_cr = 1'b0;
    endfunction

    // Emit a content byte unless the field is already full
    function void append(fid_t f, logic [BYTE_W-1:0] c, int cap);
      if (len >= cap) begin
        abort(ST_TOO_LONG);
        return;
      end
      add_token(KIND_CONTENT, f, slot_for(f), c, '0, '0, ST_OK);
      len++;
    endfunction

    function void close_field(fid_t f);
      add_token(KIND_END, f, slot_for(f), '0, len, '0, ST_OK);
      len = '0;
    endfunction

    function void name_char(logic [BYTE_W-1:0] c);
      if (c == CH_COLON) begin
        close_field(FID_HNAME);
        ph = PH_VSKIP;
      end else begin
        append(FID_HNAME, (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c, FIELD_CAP);
      end
    endfunction

    // Route one byte that is not part of a line end
    function void take_char(logic [BYTE_W-1:0] c);
      logic [HCNT_W-1:0] hlim;
      hlim = (hdr_lim < MAX_HEADERS) ? hdr_lim : HCNT_W'(MAX_HEADERS);
      case (ph)
        PH_METHOD: begin
          if (c == CH_SP) begin
            close_field(FID_METHOD);
            ph = PH_PATH;
          end else begin
            append(FID_METHOD, c, SHORT_FIELD_CAP);
          end
        end
        PH_PATH: begin
          if (c == CH_SP) begin
            close_field(FID_PATH);
            ph = PH_VERSION;
          end else begin
            append(FID_PATH, c, FIELD_CAP);
          end
        end
        PH_VERSION: append(FID_VERSION, c, SHORT_FIELD_CAP);
        PH_LINE: begin
          // Lines past the header limit are only scanned for a colon
          if (hnum >= hlim) begin
            ph = (c == CH_COLON) ? PH_SKIP_COLON : PH_SKIP_NOCOLON;
          end else begin
            ph  = PH_HNAME;
            len = '0;
            name_char(c);
          end
        end
        PH_HNAME: name_char(c);
        PH_VSKIP: begin
          if (c != CH_SP) begin
            ph = PH_VALUE;
            append(FID_HVALUE, c, FIELD_CAP);
          end
        end
        PH_VALUE: append(FID_HVALUE, c, FIELD_CAP);
        PH_SKIP_NOCOLON: begin
          if (c == CH_COLON) ph = PH_SKIP_COLON;
        end
        default: ;
      endcase
    endfunction

    function void take_line_end();
      case (ph)
        PH_METHOD, PH_PATH: abort(ST_BAD_LINE);
        PH_VERSION: begin
          close_field(FID_VERSION);
          ph = PH_LINE;
        end
        PH_LINE: begin
          len = '0;
          ph  = PH_BODY;
        end
        PH_HNAME, PH_SKIP_NOCOLON: abort(ST_NO_COLON);
        PH_VSKIP, PH_VALUE: begin
          close_field(FID_HVALUE);
          hnum++;
          ph = PH_LINE;
        end
        PH_SKIP_COLON: abort(ST_TOO_MANY);
        default: ;
      endcase
    endfunction

    // Advance on one accepted item and queue the tokens it causes
    function void take_byte(logic [BYTE_W-1:0] b, logic fin);
      logic [LEN_W-1:0] blim;
      bit               line_done;
      blim = (body_lim < BODY_MAX) ? body_lim : LEN_W'(BODY_MAX);
      step_tokens.delete();
      line_done = 1'b0;
      if (ph == PH_BODY) begin
        if (len < blim) begin
          add_token(KIND_CONTENT, FID_BODY, '0, b, '0, '0, ST_OK);
          len++;
        end
      end else if (ph != PH_ERR) begin
        // A held CR either closes a line or becomes content
        if (held_cr) begin
          held_cr = 1'b0;
          if (b == CH_LF) begin
            take_line_end();
            line_done = 1'b1;
          end else begin
            take_char(CH_CR);
          end
        end
        if (!line_done && ph != PH_ERR) begin
          if (b == CH_CR) held_cr = 1'b1;
          else take_char(b);
        end
      end
      if (fin) begin
        if (ph == PH_BODY)
          add_token(KIND_STATUS, FID_METHOD, '0, '0, len, hnum, ST_OK);
        else if (ph == PH_ERR)
          add_token(KIND_STATUS, FID_METHOD, '0, '0, '0, hnum, err);
        else
          add_token(KIND_STATUS, FID_METHOD, '0, '0, '0, hnum, ST_INCOMPLETE);
        restart();
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
      foreach (step_tokens[i]) due_tokens.push_back(step_tokens[i]);
    endfunction

    function string show(token_t t);
      return $sformatf("kind=%0d fid=%0d slot=%0d byte=%02h len=%0d seen=%0d st=%0d end=%0b",
                       t.kind, t.fid, t.slot, t.data, t.flen, t.seen, t.status, t.last);
    endfunction

    // Compare one output item against the oldest owed token
    function void match_token(token_t got);
      token_t want;
      if (due_tokens.size() == 0) begin
        if (bad_count < 10) $display("unexpected result: %s", show(got));
        bad_count++;
        return;
      end
      want = due_tokens.pop_front();
      if (got.kind !== want.kind || got.fid !== want.fid || got.slot !== want.slot ||
          got.data !== want.data || got.flen !== want.flen || got.seen !== want.seen ||
          got.status !== want.status || got.last !== want.last) begin
        if (bad_count < 10) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
        bad_count++;
      end
    endfunction

    function void close_out();
      if (due_tokens.size() != 0) begin
        if (bad_count < 10)
          $display("%0d results never arrived, next %s", due_tokens.size(),
                   show(due_tokens[0]));
        bad_count++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  hrsp_in_if  in_if();
  hrsp_out_if out_if();

  http_request_stream_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_if    (in_if),
    .out_if   (out_if)
  );

  parse_tracker      tracker = new();
  logic [BYTE_W-1:0] req_q[$];
  int                sent = 0;
  int                burst_left = 0;
  int                stall_cyc = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure: rotate through free-running, sparse, periodic and coin-flip
  always @(negedge clk) begin
    stall_cyc++;
    case (stall_cyc[8:7])
      2'd0:    out_if.ready <= 1'b1;
      2'd1:    out_if.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_if.ready <= ((stall_cyc % 5) > 1);
      default: out_if.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    token_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) tracker.take_byte(in_if.data_byte, in_if.is_final);
      if (out_if.valid && out_if.ready) begin
        got.kind   = kind_t'(out_if.kind);
        got.fid    = fid_t'(out_if.field_id);
        got.slot   = out_if.header_slot;
        got.data   = out_if.out_byte;
        got.flen   = out_if.field_length;
        got.seen   = out_if.headers_seen;
        got.status = status_t'(out_if.status);
        got.last   = out_if.run_end;
        tracker.match_token(got);
      end
    end
  end

  // Send one item, opening a new burst with a random gap when the old one runs out
  task automatic send_byte(logic [BYTE_W-1:0] b, logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.is_final  = fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_request();
    foreach (req_q[i]) send_byte(req_q[i], i == req_q.size() - 1);
  endtask

  // Hold the sender until every owed result is out, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (tracker.due_tokens.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = v;
    tracker.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(logic [BYTE_W-1:0] bar_a,
                                                  logic [BYTE_W-1:0] bar_b);
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(0, 255));
    while (c == CH_CR || c == bar_a || c == bar_b);
    return c;
  endfunction

  // Field content, now and then a lone CR, optionally heavy on capitals
  function automatic void add_field(int n, logic [BYTE_W-1:0] bar, bit upper);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        req_q.push_back(CH_CR);
        req_q.push_back(pick_byte(bar, CH_LF));
      end else if (upper && $urandom_range(0, 1) == 1) begin
        req_q.push_back(BYTE_W'($urandom_range(CH_UP_A, CH_UP_Z)));
      end else begin
        req_q.push_back(pick_byte(bar, CH_CR));
      end
    end
  endfunction

  function automatic void add_crlf();
    req_q.push_back(CH_CR);
    req_q.push_back(CH_LF);
  endfunction

  function automatic void load_text(string s);
    req_q.delete();
    for (int i = 0; i < s.len(); i++) req_q.push_back(s[i]);
  endfunction

  // Build one buffer: mostly well-formed, some cut short, broken or pure noise.
  // long_kind stretches the path (1), a header name (2) or a header value (3).
  function automatic void build_request(int long_kind);
    int mode;
    int nh;
    int hlim_now;
    int keep;
    req_q.delete();
    mode     = $urandom_range(0, 9);
    hlim_now = (tracker.hdr_lim < MAX_HEADERS) ? tracker.hdr_lim : MAX_HEADERS;
    if (long_kind != 0) mode = 0;
    if (mode == 8) begin
      repeat ($urandom_range(1, 12)) req_q.push_back(BYTE_W'($urandom_range(0, 255)));
      return;
    end
    add_field(($urandom_range(0, 7) == 0) ? 17 : $urandom_range(0, 6), CH_SP, 1'b1);
    if (mode == 9 && $urandom_range(0, 2) == 0) add_crlf();
    req_q.push_back(CH_SP);
    add_field((long_kind == 1) ? $urandom_range(257, 260) : $urandom_range(0, 8), CH_SP, 1'b0);
    if (mode == 9 && $urandom_range(0, 2) == 0) add_crlf();
    req_q.push_back(CH_SP);
    add_field(($urandom_range(0, 7) == 0) ? 17 : $urandom_range(0, 7), CH_CR, 1'b0);
    add_crlf();
    nh = ($urandom_range(0, 5) == 0) ? hlim_now + $urandom_range(0, 2) : $urandom_range(0, 3);
    // One stretched header line is enough
    if (long_kind > 1) nh = 1;
    for (int h = 0; h < nh; h++) begin
      add_field((long_kind == 2) ? 257 : $urandom_range(0, 5), CH_COLON, 1'b1);
      // Drop the colon to break the line
      if (mode == 9 && $urandom_range(0, 2) == 0) begin
        add_crlf();
        continue;
      end
      req_q.push_back(CH_COLON);
      repeat ($urandom_range(0, 2)) req_q.push_back(CH_SP);
      add_field((long_kind == 3) ? 257 : $urandom_range(0, 5), CH_CR, 1'b0);
      add_crlf();
    end
    add_crlf();
    repeat ($urandom_range(0, 6)) req_q.push_back(BYTE_W'($urandom_range(0, 255)));
    if (mode == 7) begin
      keep = $urandom_range(1, req_q.size());
      while (req_q.size() > keep) void'(req_q.pop_back());
    end
  endfunction

  initial begin
    int goal;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_BODY_LIMIT;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.is_final  = 1'b0;
    out_if.ready    = 1'b1;
    tracker.power_on();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: every field, a header, a body, CRLF in the method, trailing CR, lone CR
    load_text("G / H\015\012A: v\015\012\015\012b");
    send_request();
    load_text("\015\012");
    send_request();
    load_text("\015");
    send_request();
    load_text("\377\015\001");
    send_request();
    drain();

    // Random buffers under a sequence of register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin
          write_cfg(CFG_BODY_LIMIT, '0);
          write_cfg(CFG_HEADER_LIMIT, '0);
        end
        2: begin
          write_cfg(CFG_BODY_LIMIT, CFG_DATA_W'(3));
          write_cfg(CFG_HEADER_LIMIT, CFG_DATA_W'(2));
        end
        3: begin
          write_cfg(CFG_BODY_LIMIT, '1);
          write_cfg(CFG_HEADER_LIMIT, CFG_DATA_W'(31));
        end
        4: begin
          write_cfg(CFG_BODY_LIMIT, CFG_DATA_W'($urandom_range(0, 1024)));
          write_cfg(CFG_HEADER_LIMIT, CFG_DATA_W'($urandom_range(0, 16)));
        end
        5: begin
          write_cfg(CFG_BODY_LIMIT, CFG_DATA_W'(1024));
          write_cfg(CFG_HEADER_LIMIT, CFG_DATA_W'(16));
        end
        default: ;
      endcase
      if (p == 0) begin
        build_request($urandom_range(1, 3));
        send_request();
      end
      // Spread the rest of the item budget over the remaining settings
      goal = sent + (ITEM_GOAL - sent) / (6 - p);
      while (sent < goal) begin
        build_request(0);
        send_request();
        if ($urandom_range(0, 14) == 0) drain();
      end
      drain();
    end

    tracker.close_out();
    if (tracker.bad_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: http_request_stream_parser.f
+incdir+design
design/hrsp_pkg.sv
design/hrsp_in_if.sv
design/hrsp_out_if.sv
design/hrsp_queue.sv
design/hrsp_front.sv
design/hrsp_back.sv
design/http_request_stream_parser.sv
test/tb.sv
